// File: rtl/hybrid_logical_clock_unit_top_assert.svh
// Assertion macros for the hybrid logical clock unit checker.
// Each macro expects clk, and HLC_ASSERT also arst_n, to be visible where it is used.
`ifndef HYBRID_LOGICAL_CLOCK_UNIT_TOP_ASSERT_SVH
`define HYBRID_LOGICAL_CLOCK_UNIT_TOP_ASSERT_SVH

// Clocked check, muted while reset is asserted
`define HLC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define HLC_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hlc_pkg.sv
// Shared types, op codes and saturating arithmetic for the hybrid logical clock unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hlc_pkg;

	// Signed range that offset sums saturate into
	localparam int TIME_WIDTH = 64;
	localparam logic signed [64:0] T_MAX = $signed((65'd1 << (TIME_WIDTH - 1)) - 65'd1);
	localparam logic signed [64:0] T_MIN = -T_MAX - 65'sd1;

	// Operation codes
	localparam logic [2:0] OP_STAMP    = 3'd0;
	localparam logic [2:0] OP_STAMP_AT = 3'd1;
	localparam logic [2:0] OP_MERGE    = 3'd2;
	localparam logic [2:0] OP_SERVICE  = 3'd3;
	localparam logic [2:0] OP_REBASE   = 3'd4;
	localparam logic [2:0] OP_RESTORE  = 3'd5;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [63:0] local_now_ms;
		logic signed [63:0] local_order_ms;
		logic [62:0]        remote_physical_ms;
		logic [63:0]        remote_counter;
		logic signed [63:0] server_time_ms;
		logic signed [63:0] request_sent_ms;
		logic signed [63:0] response_received_ms;
		logic signed [63:0] restore_physical_ms;
		logic [63:0]        restore_counter;
		logic signed [63:0] restore_offset_ms;
	} hlc_req_t;

	typedef struct packed {
		logic [62:0]        physical_ms;
		logic [63:0]        logical_count;
		logic signed [63:0] offset_ms;
		logic               stamp_valid;
	} hlc_rsp_t;

	typedef struct packed {
		logic [62:0]        phys;
		logic [63:0]        count;
		logic signed [63:0] offset;
	} hlc_state_t;

	// Clamp a 65-bit exact value into the time range
	function automatic logic signed [63:0] clamp_t(input logic signed [64:0] v);
		logic signed [64:0] r;
		if (v > T_MAX) begin
			r = T_MAX;
		end else if (v < T_MIN) begin
			r = T_MIN;
		end else begin
			r = v;
		end
		return $signed(r[63:0]);
	endfunction

	// Exact 65-bit sum, then clamp
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		return clamp_t(s);
	endfunction

	// Negative values go to zero
	function automatic logic [62:0] floor_zero(input logic signed [63:0] v);
		return v[63] ? 63'd0 : v[62:0];
	endfunction

	// Local time plus offset, zero for a negative local time
	function automatic logic [62:0] adjusted_now(input logic signed [63:0] now,
			input logic signed [63:0] off);
		logic signed [63:0] s;
		s = sat_add(now, off);
		return now[63] ? 63'd0 : floor_zero(s);
	endfunction

endpackage

`default_nettype wire

// File: rtl/hlc_core.sv
// Next-state logic of the hybrid logical clock: one request against the current state.
// Depends on hlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlc_core (
	input  wire hlc_pkg::hlc_state_t cur,
	input  wire hlc_pkg::hlc_req_t   req,
	output hlc_pkg::hlc_state_t      nxt,
	output logic                     stamp
);

	logic [62:0]        adj;
	logic               order_pos;
	logic [62:0]        order_adj;
	logic [62:0]        cand;
	logic [62:0]        np_a;
	logic [62:0]        np;
	logic [63:0]        cnt_max;
	logic               svc_ok;
	logic [63:0]        rtt;
	logic signed [63:0] mid;
	logic signed [63:0] svc_off;

	// Adjusted now and the ordering-time candidate
	assign adj       = hlc_pkg::adjusted_now(req.local_now_ms, cur.offset);
	assign order_pos = !req.local_order_ms[63] && (req.local_order_ms != 64'sd0);
	assign order_adj = hlc_pkg::floor_zero(hlc_pkg::sat_add(req.local_order_ms, cur.offset));
	assign cand      = (req.op == hlc_pkg::OP_STAMP_AT && order_pos) ? order_adj : adj;

	// Merge: largest of own, remote and adjusted now
	assign np_a    = (cur.phys > req.remote_physical_ms) ? cur.phys : req.remote_physical_ms;
	assign np      = (adj > np_a) ? adj : np_a;
	assign cnt_max = (cur.count > req.remote_counter) ? cur.count : req.remote_counter;

	// Round-trip offset estimate; midpoint truncated
	assign svc_ok  = (req.server_time_ms > 64'sd0) && (req.request_sent_ms > 64'sd0)
		&& (req.response_received_ms >= req.request_sent_ms);
	assign rtt     = req.response_received_ms - req.request_sent_ms;
	assign mid     = req.request_sent_ms + $signed({1'b0, rtt[63:1]});
	assign svc_off = hlc_pkg::clamp_t($signed({req.server_time_ms[63], req.server_time_ms})
		- $signed({mid[63], mid}));

	always_comb begin
		nxt   = cur;
		stamp = 1'b0;
		unique case (req.op)
			hlc_pkg::OP_STAMP, hlc_pkg::OP_STAMP_AT: begin
				stamp = 1'b1;
				if (cand > cur.phys) begin
					nxt.phys  = cand;
					nxt.count = '0;
				end else begin
					nxt.count = cur.count + 64'd1;
				end
			end
			hlc_pkg::OP_MERGE: begin
				nxt.phys = np;
				priority if (np == cur.phys && np == req.remote_physical_ms) begin
					nxt.count = cnt_max + 64'd1;
				end else if (np == cur.phys) begin
					nxt.count = cur.count + 64'd1;
				end else if (np == req.remote_physical_ms) begin
					nxt.count = req.remote_counter + 64'd1;
				end else begin
					nxt.count = '0;
				end
			end
			hlc_pkg::OP_SERVICE: begin
				if (svc_ok) begin
					nxt.offset = svc_off;
				end
			end
			hlc_pkg::OP_REBASE: begin
				nxt.phys  = adj;
				nxt.count = '0;
			end
			hlc_pkg::OP_RESTORE: begin
				nxt.phys   = hlc_pkg::floor_zero(req.restore_physical_ms);
				nxt.count  = req.restore_counter;
				nxt.offset = req.restore_offset_ms;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/hybrid_logical_clock_unit_top.sv
// Hybrid logical clock unit. A request passes the input register, then the response
// register; a stalled response (rsp_ready low) holds both stages.
// Throughput: one request per cycle while responses are taken; the clock state register
// is read and written in the same cycle by the single next-state stage, which sets that rate.
// Reset: clock state (time, counter, offset) clears to zero and both stages empty.
// Depends on hlc_pkg and hlc_core.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_logical_clock_unit_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire hlc_pkg::hlc_req_t req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output hlc_pkg::hlc_rsp_t      rsp_data
);

	logic                valid_s1;
	hlc_pkg::hlc_req_t   req_s1;
	hlc_pkg::hlc_state_t state_q;
	hlc_pkg::hlc_state_t state_nxt;
	logic                stamp;
	logic                rsp_valid_q;
	hlc_pkg::hlc_rsp_t   rsp_q;
	logic                adv;

	// Stage 1 moves on when the response register is free or being drained
	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
	end

	hlc_core u_core (
		.cur   (state_q),
		.req   (req_s1),
		.nxt   (state_nxt),
		.stamp (stamp)
	);

	// Clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			rsp_q.physical_ms   <= state_nxt.phys;
			rsp_q.logical_count <= state_nxt.count;
			rsp_q.offset_ms     <= state_nxt.offset;
			rsp_q.stamp_valid   <= stamp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/hlc_checker.sv
// Port-level checks for the hybrid logical clock unit, bound to the top level.
// Depends on hlc_pkg and hybrid_logical_clock_unit_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "hybrid_logical_clock_unit_top_assert.svh"

module hlc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire hlc_pkg::hlc_rsp_t rsp_data
);

	// A stalled response holds
	`HLC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp moved")

	// With the response register empty the unit always takes a request
	`HLC_ASSERT(a_ready_empty, !rsp_valid |-> req_ready, "request refused with empty output")

	// A request taken into an empty output path leads to a valid response
	`HLC_ASSERT(a_latency, req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid, "rsp missing")

	// Nothing is offered while in reset
	`HLC_ASSERT_ANY(a_reset_idle, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

bind hybrid_logical_clock_unit_top hlc_checker u_hlc_checker (.*);

`default_nettype wire
